### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dbd_pkg.sv
// types, constants and helper functions for the days-between-dates core
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

  localparam int unsigned DayW    = 6;   // day field after decode, up to 45
  localparam int unsigned MonW    = 8;   // month field after decode, up to 165
  localparam int unsigned YrW     = 15;  // year field after decode, up to 16665
  localparam int unsigned DateW   = 30;
  localparam int unsigned DnW     = 23;  // day number without the minus one
  localparam int unsigned CumW    = 9;
  localparam int unsigned QuadW   = 13;  // y / 4
  localparam int unsigned CentW   = 8;   // y / 100
  localparam int unsigned OutW    = 23;
  localparam int unsigned ProdW   = 26;

  localparam logic [DnW-1:0]   DaysPerYear = 23'd365;
  // y/100 = (y/4)/25, and (y/4)/25 = ((y/4) * 5243) >> 17 for y/4 below 4167
  localparam logic [ProdW-1:0] Recip25     = 26'd5243;
  localparam int unsigned      Recip25Sh   = 17;
  localparam logic [OutW-1:0]  OutMax      = 23'd4194303;

  typedef struct packed {
    logic [DayW-1:0] day;
    logic [MonW-1:0] mon;
    logic [YrW-1:0]  yr;
  } date_t;

  typedef struct packed {
    logic [DnW-1:0]   yr365;
    logic [CumW-1:0]  cum;
    logic [DayW-1:0]  day;
    logic [QuadW-1:0] q;
  } s2_t;

  typedef struct packed {
    logic [DnW-1:0]   base;
    logic [QuadW-1:0] q;
    logic [CentW-1:0] c;
  } s3_t;

  // nibbles D1 D0 M1 M0 Y3 Y2 Y1 Y0 from the top down, weighted as they stand
  function automatic date_t decode_date(input logic [DateW-1:0] v);
    date_t d;
    d.day = 6'(v[29:28]) * 6'd10 + 6'(v[27:24]);
    d.mon = 8'(v[23:20]) * 8'd10 + 8'(v[19:16]);
    d.yr  = 15'(v[15:12]) * 15'd1000 + 15'(v[11:8]) * 15'd100
          + 15'(v[7:4]) * 15'd10 + 15'(v[3:0]);
    return d;
  endfunction

  // days of the months before this one; month zero adds none, past twelve adds all
  function automatic logic [CumW-1:0] cum_days(input logic [MonW-1:0] mon);
    logic [CumW-1:0] r;
    unique case (mon)
      8'd0, 8'd1: r = 9'd0;
      8'd2:       r = 9'd31;
      8'd3:       r = 9'd59;
      8'd4:       r = 9'd90;
      8'd5:       r = 9'd120;
      8'd6:       r = 9'd151;
      8'd7:       r = 9'd181;
      8'd8:       r = 9'd212;
      8'd9:       r = 9'd243;
      8'd10:      r = 9'd273;
      8'd11:      r = 9'd304;
      8'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/days_between_dates_core.sv
// days strictly between two bcd dates, five-stage pipeline
//
//  channel  dir  payload
//  s_axis   in   tdata: first_date_bcd, second_date_bcd; tuser: presence flags
//  m_axis   out  tdata: days_between (signed 23 bits)
//
// the pipe takes one beat per cycle when the output side keeps tready high.
// the whole pipe advances together when the output register is empty or
// being taken, so a stall at the output freezes every stage and holds tready
// low. the two multiplies (year times 365 and the reciprocal for the century
// count) each sit alone in a stage. rst clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module days_between_dates_core
  import dbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [29:0] first_date_bcd, [59:30] second_date_bcd
  input  wire logic [1:0]  s_axis_tuser,   // [0] first_present, [1] second_present
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // [22:0] days_between
);

  logic adv;

  logic  v1, v2, v3, v4;
  logic  absent1, absent2, absent3, absent4;
  logic  same2, same3, same4;
  date_t date1 [2];
  s2_t   st2 [2];
  s3_t   st3 [2];
  logic [DnW-1:0] dn4 [2];

  logic [OutW-1:0] days;
  logic [OutW-1:0] days_next;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tdata  = {1'b0, days};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      m_axis_tvalid <= v4;
    end
  end

  // stage 1: nibble decode
  always_ff @(posedge clk) begin
    if (adv) begin
      date1[0] <= decode_date(s_axis_tdata[29:0]);
      date1[1] <= decode_date(s_axis_tdata[59:30]);
      absent1  <= !(s_axis_tuser[0] && s_axis_tuser[1]);
    end
  end

  // stage 2: year times 365, month table, leap base year
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        st2[i].yr365 <= DnW'(date1[i].yr) * DaysPerYear;
        st2[i].cum   <= cum_days(date1[i].mon);
        st2[i].day   <= date1[i].day;
        // january and february count leaps up to the year before; year zero stays zero
        if (date1[i].mon <= 8'd2 && date1[i].yr != '0) begin
          st2[i].q <= QuadW'((date1[i].yr - 15'd1) >> 2);
        end else begin
          st2[i].q <= QuadW'(date1[i].yr >> 2);
        end
      end
      same2   <= (date1[0] == date1[1]);
      absent2 <= absent1;
    end
  end

  // stage 3: century count by reciprocal, partial day number
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        st3[i].c    <= CentW'((ProdW'(st2[i].q) * Recip25) >> Recip25Sh);
        st3[i].q    <= st2[i].q;
        st3[i].base <= st2[i].yr365 + DnW'(st2[i].day) + DnW'(st2[i].cum);
      end
      same3   <= same2;
      absent3 <= absent2;
    end
  end

  // stage 4: add leap count y/4 - y/100 + y/400
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        dn4[i] <= st3[i].base
                + DnW'(st3[i].q - QuadW'(st3[i].c) + QuadW'(st3[i].c >> 2));
      end
      same4   <= same3;
      absent4 <= absent3;
    end
  end

  // stage 5: |difference| - 1 with saturation; -1 if a date is absent, 0 if equal
  logic [DnW:0] diff;
  logic [DnW:0] mag_m1;

  always_comb begin
    diff   = {1'b0, dn4[0]} - {1'b0, dn4[1]};
    // for a negative difference, -diff - 1 is ~diff
    mag_m1 = diff[DnW] ? ~diff : diff - 24'd1;
    priority if (absent4) begin
      days_next = '1;
    end else if (same4) begin
      days_next = '0;
    end else if (mag_m1 == '1) begin
      days_next = '1;
    end else if (mag_m1 > (DnW + 1)'(OutMax)) begin
      days_next = OutMax;
    end else begin
      days_next = mag_m1[OutW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      days <= days_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dbd_checker.sv
// port-level checker for the days-between-dates core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  logic out_stall;
  logic result_ok;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  // result is -1 or within 0 .. 4194303, pad bit clear
  assign result_ok = !m_axis_tdata[23] && (!m_axis_tdata[22] || (&m_axis_tdata[22:0]));

  // the input side only backs up behind a stalled output beat
  `ASSERT_IMPL(a_ready_unless_stall, clk, rst, !out_stall, s_axis_tready, "input stalled")

  `ASSERT_IMPL(a_result_range, clk, rst, m_axis_tvalid, result_ok, "result out of range")

  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid, "output beat dropped")

  `ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable(m_axis_tdata), "output beat changed")

endmodule

bind days_between_dates_core dbd_checker u_dbd_checker (.*);

`default_nettype wire
